>>> rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while rst is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("kct assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("kct assertion failed");

`endif

>>> rtl/kct_pkg.sv
// Package: types, codes, reset values and digit helpers of the kitchen timer.
`timescale 1ns / 1ps

package kct_pkg;

  localparam int ADDR_W = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SET_KEY_LOW    = 3'd0;
  localparam logic [2:0] REG_PLUS_KEY_LOW   = 3'd1;
  localparam logic [2:0] REG_PLUS_KEY_HIGH  = 3'd2;
  localparam logic [2:0] REG_MINUS_KEY_LOW  = 3'd3;
  localparam logic [2:0] REG_MINUS_KEY_HIGH = 3'd4;
  localparam logic [2:0] REG_ALARM_LENGTH   = 3'd5;
  localparam logic [2:0] REG_MINUTE_LIMIT   = 3'd6;

  localparam logic [9:0] RST_SET_KEY_LOW    = 10'd950;
  localparam logic [9:0] RST_PLUS_KEY_LOW   = 10'd470;
  localparam logic [9:0] RST_PLUS_KEY_HIGH  = 10'd530;
  localparam logic [9:0] RST_MINUS_KEY_LOW  = 10'd300;
  localparam logic [9:0] RST_MINUS_KEY_HIGH = 10'd400;
  localparam logic [7:0] RST_ALARM_LENGTH   = 8'd5;
  localparam logic [6:0] RST_MINUTE_LIMIT   = 7'd99;

  localparam logic [6:0] MAX_MINUTES = 7'd99;
  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam logic [5:0] SEC_STEP    = 6'd10;
  localparam logic [5:0] SEC_PLUS_MAX = 6'd50;
  localparam logic [5:0] SEC_BORROW  = 6'd50;

  localparam logic [1:0] KEY_SET   = 2'd0;
  localparam logic [1:0] KEY_PLUS  = 2'd1;
  localparam logic [1:0] KEY_MINUS = 2'd2;
  localparam logic [1:0] KEY_NONE  = 2'd3;

  localparam logic [2:0] MODE_MIN   = 3'd0;
  localparam logic [2:0] MODE_SEC   = 3'd1;
  localparam logic [2:0] MODE_RUN   = 3'd2;
  localparam logic [2:0] MODE_PAUSE = 3'd3;
  localparam logic [2:0] MODE_ALARM = 3'd4;

  localparam logic [7:0] COLON_BIT = 8'h80;

  typedef struct packed {
    logic [9:0] key_level;
    logic       second_tick;
  } poll_t;

  typedef struct packed {
    logic [2:0]  timer_mode;
    logic [12:0] seconds_left;
    logic [7:0]  digit_one;
    logic [7:0]  digit_two;
    logic [7:0]  digit_three;
    logic [7:0]  digit_four;
    logic        display_refresh;
    logic        alarm_on;
    logic [1:0]  key_code;
  } result_t;

  // Seven-segment code of one decimal digit; blank above nine.
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Tens digit by reciprocal multiply, exact for values below 128.
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(input logic [6:0] v, input logic [3:0] t);
    logic [6:0] u;
    u = v - ({3'd0, t} << 3) - ({3'd0, t} << 1);
    return u[3:0];
  endfunction

endpackage

>>> rtl/kitchen_countdown_timer_controller.sv
// Top level of the kitchen countdown timer: key decode, mode control and display codes.
//
//   channel  | direction | handshake                     | payload
//   ---------+-----------+-------------------------------+---------------------------
//   poll     | in        | poll_valid / poll_ready       | poll_t (key level, tick)
//   result   | out       | result_valid / result_ready   | result_t (mode, time, digits)
//   config   | in        | psel, penable, pwrite, pready | paddr / pwdata / prdata
//
// One poll per cycle sustained while the result side does not stall. A poll is held
// in an input register, the next timer state and display codes are built in one short
// pass, and both land in the result register on the edge at which the held poll advances.
// rst (synchronous) clears the control state and restores the register defaults.
// A stalled result register holds the input register; the input register still takes
// a new poll in the same cycle in which the waiting result transaction completes.
`timescale 1ns / 1ps

module kitchen_countdown_timer_controller
  import kct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              poll_valid,
  output logic              poll_ready,
  input  poll_t             poll,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ---------------- configuration registers ----------------
  logic [9:0] set_key_low;
  logic [9:0] plus_key_low;
  logic [9:0] plus_key_high;
  logic [9:0] minus_key_low;
  logic [9:0] minus_key_high;
  logic [7:0] alarm_length;
  logic [6:0] minute_limit;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = paddr[4:2];

  // Write on the access phase; indexes past the list drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_key_low    <= RST_SET_KEY_LOW;
      plus_key_low   <= RST_PLUS_KEY_LOW;
      plus_key_high  <= RST_PLUS_KEY_HIGH;
      minus_key_low  <= RST_MINUS_KEY_LOW;
      minus_key_high <= RST_MINUS_KEY_HIGH;
      alarm_length   <= RST_ALARM_LENGTH;
      minute_limit   <= RST_MINUTE_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SET_KEY_LOW:    set_key_low    <= pwdata[9:0];
        REG_PLUS_KEY_LOW:   plus_key_low   <= pwdata[9:0];
        REG_PLUS_KEY_HIGH:  plus_key_high  <= pwdata[9:0];
        REG_MINUS_KEY_LOW:  minus_key_low  <= pwdata[9:0];
        REG_MINUS_KEY_HIGH: minus_key_high <= pwdata[9:0];
        REG_ALARM_LENGTH:   alarm_length   <= pwdata[7:0];
        REG_MINUTE_LIMIT:   minute_limit   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_SET_KEY_LOW:    prdata = {22'd0, set_key_low};
      REG_PLUS_KEY_LOW:   prdata = {22'd0, plus_key_low};
      REG_PLUS_KEY_HIGH:  prdata = {22'd0, plus_key_high};
      REG_MINUS_KEY_LOW:  prdata = {22'd0, minus_key_low};
      REG_MINUS_KEY_HIGH: prdata = {22'd0, minus_key_high};
      REG_ALARM_LENGTH:   prdata = {24'd0, alarm_length};
      REG_MINUTE_LIMIT:   prdata = {25'd0, minute_limit};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------- input register and flow control ----------------
  logic  hold_valid;
  poll_t hold;
  logic  advance;

  // Advance the held poll whenever the result register is free or being emptied.
  assign advance    = hold_valid & (~result_valid | result_ready);
  assign poll_ready = ~hold_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (poll_ready) begin
      hold_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_ready && poll_valid) begin
      hold <= poll;
    end
  end

  // ---------------- timer state ----------------
  // Remaining time is kept as minutes and seconds; the total always has that form.
  logic [2:0] mode;
  logic [6:0] mins;
  logic [5:0] secs;
  logic       colon_on;
  logic [7:0] alarm_left;
  logic       buzzer;

  logic [2:0] mode_next;
  logic [6:0] mins_next;
  logic [5:0] secs_next;
  logic       colon_next;
  logic [7:0] alarm_left_next;
  logic       buzzer_next;
  logic       refresh;

  logic [1:0] key;
  logic       tick;
  logic [6:0] limit;
  logic [7:0] alarm_dec;
  logic       alarm_off;

  assign tick  = hold.second_tick;
  assign limit = (minute_limit > MAX_MINUTES) ? MAX_MINUTES : minute_limit;

  // Set wins over plus, plus over minus.
  always_comb begin
    if (hold.key_level >= set_key_low) begin
      key = KEY_SET;
    end else if (hold.key_level >= plus_key_low && hold.key_level <= plus_key_high) begin
      key = KEY_PLUS;
    end else if (hold.key_level >= minus_key_low && hold.key_level <= minus_key_high) begin
      key = KEY_MINUS;
    end else begin
      key = KEY_NONE;
    end
  end

  always_comb begin
    mode_next       = mode;
    mins_next       = mins;
    secs_next       = secs;
    colon_next      = colon_on;
    alarm_left_next = alarm_left;
    buzzer_next     = buzzer;
    refresh         = 1'b0;
    alarm_dec       = alarm_left;
    alarm_off       = 1'b0;

    case (mode)
      MODE_MIN: begin
        if (key == KEY_PLUS && mins < limit) mins_next = mins + 7'd1;
        if (key == KEY_MINUS && mins != 7'd0) mins_next = mins - 7'd1;
        if (key == KEY_SET) mode_next = MODE_SEC;
        if (key != KEY_NONE) refresh = 1'b1;
      end
      MODE_SEC: begin
        if (key == KEY_PLUS && secs < SEC_PLUS_MAX) secs_next = secs + SEC_STEP;
        if (key == KEY_MINUS) begin
          // Drop ten seconds, borrow a minute, saturate at zero.
          if (secs >= SEC_STEP) begin
            secs_next = secs - SEC_STEP;
          end else if (mins != 7'd0) begin
            mins_next = mins - 7'd1;
            secs_next = secs + SEC_BORROW;
          end else begin
            secs_next = 6'd0;
          end
        end
        if (key == KEY_SET) mode_next = MODE_RUN;
        if (key != KEY_NONE) refresh = 1'b1;
      end
      MODE_RUN: begin
        if (key == KEY_SET || key == KEY_MINUS) begin
          mode_next  = MODE_MIN;
          mins_next  = 7'd0;
          secs_next  = 6'd0;
          colon_next = 1'b1;
          refresh    = 1'b1;
        end
        if (key == KEY_PLUS) mode_next = MODE_PAUSE;
      end
      MODE_PAUSE: begin
        colon_next = 1'b1;
        if (key == KEY_PLUS) mode_next = MODE_RUN;
        if (key == KEY_SET || key == KEY_MINUS) begin
          mode_next = MODE_MIN;
          mins_next = 7'd0;
          secs_next = 6'd0;
          refresh   = 1'b1;
        end
      end
      MODE_ALARM: begin
        if (tick && alarm_left != 8'd0) alarm_dec = alarm_left - 8'd1;
        alarm_off = (alarm_dec == 8'd0) || (key != KEY_NONE);
        if (alarm_off) begin
          mode_next       = MODE_MIN;
          mins_next       = 7'd0;
          secs_next       = 6'd0;
          colon_next      = 1'b1;
          refresh         = 1'b1;
          alarm_left_next = alarm_length;
        end else begin
          alarm_left_next = alarm_dec;
        end
        buzzer_next = ~alarm_off;
      end
      default: begin
        // Unused mode codes fall back to the start state.
        mode_next  = MODE_MIN;
        mins_next  = 7'd0;
        secs_next  = 6'd0;
        colon_next = 1'b1;
        refresh    = 1'b1;
      end
    endcase

    // Count down after key handling; a spent count starts the alarm.
    if (tick && mode_next == MODE_RUN) begin
      if (mins_next == 7'd0 && secs_next == 6'd0) begin
        mode_next       = MODE_ALARM;
        alarm_left_next = alarm_length;
      end else if (secs_next != 6'd0) begin
        secs_next = secs_next - 6'd1;
      end else begin
        mins_next = mins_next - 7'd1;
        secs_next = LAST_SECOND;
      end
      colon_next = ~colon_next;
      refresh    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_MIN;
      mins       <= 7'd0;
      secs       <= 6'd0;
      colon_on   <= 1'b1;
      alarm_left <= RST_ALARM_LENGTH;
      buzzer     <= 1'b0;
    end else if (advance) begin
      mode       <= mode_next;
      mins       <= mins_next;
      secs       <= secs_next;
      colon_on   <= colon_next;
      alarm_left <= alarm_left_next;
      buzzer     <= buzzer_next;
    end
  end

  // ---------------- display codes and result register ----------------
  logic [12:0] total_next;
  logic [3:0]  min_tens;
  logic [3:0]  min_units;
  logic [3:0]  sec_tens;
  logic [3:0]  sec_units;

  // minutes * 60 = minutes * 64 - minutes * 4
  assign total_next = ({6'd0, mins_next} << 6) - ({6'd0, mins_next} << 2)
                    + {7'd0, secs_next};
  assign min_tens   = tens_of(mins_next);
  assign min_units  = units_of(mins_next, min_tens);
  assign sec_tens   = tens_of({1'b0, secs_next});
  assign sec_units  = units_of({1'b0, secs_next}, sec_tens);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.timer_mode      <= mode_next;
      result.seconds_left    <= total_next;
      result.digit_one       <= seg_of(min_tens);
      result.digit_two       <= seg_of(min_units) | (colon_next ? COLON_BIT : 8'h00);
      result.digit_three     <= seg_of(sec_tens);
      result.digit_four      <= seg_of(sec_units);
      result.display_refresh <= refresh;
      result.alarm_on        <= buzzer_next;
      result.key_code        <= key;
    end
  end

endmodule

>>> rtl/kct_checker.sv
// Port-level checker for the kitchen timer and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kct_checker
  import kct_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  localparam logic [12:0] MAX_TOTAL = 13'd5999;

  // No result transaction is offered right after reset.
  `ASSERT_CLK_ALWAYS(a_idle_after_reset, rst |=> !result_valid)

  // A stalled result holds until taken.
  `ASSERT_CLK(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result))

  // The buzzer only sounds while the alarm mode is shown.
  `ASSERT_CLK(a_buzzer_in_alarm, result_valid && result.alarm_on |-> result.timer_mode == MODE_ALARM)

  // Remaining time never passes 99:59.
  `ASSERT_CLK(a_time_range, result_valid |-> result.seconds_left <= MAX_TOTAL)

endmodule

bind kitchen_countdown_timer_controller kct_checker u_kct_checker (.*);

>>> verif/kct_result_checker.sv
// Checker for the kitchen timer: tracks register writes, predicts each result, compares.
`timescale 1ns / 1ps

module kct_result_checker
  import kct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              poll_valid,
  input  logic              poll_ready,
  input  poll_t             poll,
  input  logic              result_valid,
  input  logic              result_ready,
  input  result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [2:0]        mode_now,
  output int unsigned       pending,
  output int unsigned       mismatches
);

  logic [9:0]  set_low, plus_lo, plus_hi, minus_lo, minus_hi;
  logic [7:0]  alarm_len;
  logic [6:0]  min_limit;

  logic [2:0]  mode_q;
  logic [12:0] time_q;
  logic        colon_q;
  logic [7:0]  alarm_q;
  logic        buzz_q;

  result_t     due_results[$];
  result_t     predicted;
  int unsigned results_seen = 0;

  initial mismatches = 0;
  initial pending = 0;

  assign mode_now = mode_q;

  function automatic logic [7:0] glyph(input int unsigned d);
    case (d)
      0: return 8'h3F;
      1: return 8'h06;
      2: return 8'h5B;
      3: return 8'h4F;
      4: return 8'h66;
      5: return 8'h6D;
      6: return 8'h7D;
      7: return 8'h07;
      8: return 8'h7F;
      9: return 8'h6F;
      default: return 8'h00;
    endcase
  endfunction

  // Set wins over plus, plus over minus.
  function automatic logic [1:0] decode_key(input logic [9:0] lvl);
    if (lvl >= set_low) return KEY_SET;
    if (lvl >= plus_lo && lvl <= plus_hi) return KEY_PLUS;
    if (lvl >= minus_lo && lvl <= minus_hi) return KEY_MINUS;
    return KEY_NONE;
  endfunction

  task automatic clear_to_start;
    mode_q  = MODE_MIN;
    time_q  = '0;
    colon_q = 1'b1;
  endtask

  task automatic step_timer(input poll_t p, output result_t r);
    logic [1:0]  k;
    logic        tick;
    logic        refresh;
    logic        off;
    logic [6:0]  lim;
    int unsigned mins;
    int unsigned secs;
    k       = decode_key(p.key_level);
    tick    = p.second_tick;
    refresh = 1'b0;
    lim     = (min_limit > MAX_MINUTES) ? MAX_MINUTES : min_limit;
    case (mode_q)
      MODE_MIN: begin
        if (k == KEY_PLUS && time_q / 60 < lim) time_q = time_q + 13'd60;
        if (k == KEY_MINUS && time_q / 60 > 0) time_q = time_q - 13'd60;
        if (k == KEY_SET) mode_q = MODE_SEC;
        if (k != KEY_NONE) refresh = 1'b1;
      end
      MODE_SEC: begin
        if (k == KEY_PLUS && time_q % 60 < SEC_PLUS_MAX) time_q = time_q + 13'd10;
        if (k == KEY_MINUS && time_q > 0) time_q = (time_q >= 10) ? time_q - 13'd10 : 13'd0;
        if (k == KEY_SET) mode_q = MODE_RUN;
        if (k != KEY_NONE) refresh = 1'b1;
      end
      MODE_RUN: begin
        if (k == KEY_SET || k == KEY_MINUS) begin
          clear_to_start();
          refresh = 1'b1;
        end
        if (k == KEY_PLUS) mode_q = MODE_PAUSE;
      end
      MODE_PAUSE: begin
        colon_q = 1'b1;
        if (k == KEY_PLUS) mode_q = MODE_RUN;
        if (k == KEY_SET || k == KEY_MINUS) begin
          clear_to_start();
          refresh = 1'b1;
        end
      end
      MODE_ALARM: begin
        if (tick && alarm_q > 0) alarm_q = alarm_q - 8'd1;
        off = (alarm_q == 0) || (k != KEY_NONE);
        if (off) begin
          clear_to_start();
          refresh = 1'b1;
          alarm_q = alarm_len;
        end
        buzz_q = !off;
      end
      default: begin
        clear_to_start();
        refresh = 1'b1;
      end
    endcase

    // Count down after the key has been handled.
    if (tick && mode_q == MODE_RUN) begin
      if (time_q == 0) begin
        mode_q  = MODE_ALARM;
        alarm_q = alarm_len;
      end else begin
        time_q = time_q - 13'd1;
      end
      colon_q = !colon_q;
      refresh = 1'b1;
    end

    mins = time_q / 60;
    secs = time_q % 60;
    r.timer_mode      = mode_q;
    r.seconds_left    = time_q;
    r.digit_one       = glyph(mins / 10);
    r.digit_two       = glyph(mins % 10) | (colon_q ? COLON_BIT : 8'h00);
    r.digit_three     = glyph(secs / 10);
    r.digit_four      = glyph(secs % 10);
    r.display_refresh = refresh;
    r.alarm_on        = buzz_q;
    r.key_code        = k;
  endtask

  task automatic flag(input string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    if (got.timer_mode !== want.timer_mode)
      flag($sformatf("timer_mode %0d, expected %0d", got.timer_mode, want.timer_mode));
    if (got.seconds_left !== want.seconds_left)
      flag($sformatf("seconds_left %0d, expected %0d", got.seconds_left, want.seconds_left));
    if (got.digit_one !== want.digit_one)
      flag($sformatf("digit_one %h, expected %h", got.digit_one, want.digit_one));
    if (got.digit_two !== want.digit_two)
      flag($sformatf("digit_two %h, expected %h", got.digit_two, want.digit_two));
    if (got.digit_three !== want.digit_three)
      flag($sformatf("digit_three %h, expected %h", got.digit_three, want.digit_three));
    if (got.digit_four !== want.digit_four)
      flag($sformatf("digit_four %h, expected %h", got.digit_four, want.digit_four));
    if (got.display_refresh !== want.display_refresh)
      flag($sformatf("display_refresh %b, expected %b", got.display_refresh,
                     want.display_refresh));
    if (got.alarm_on !== want.alarm_on)
      flag($sformatf("alarm_on %b, expected %b", got.alarm_on, want.alarm_on));
    if (got.key_code !== want.key_code)
      flag($sformatf("key_code %0d, expected %0d", got.key_code, want.key_code));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      set_low   = RST_SET_KEY_LOW;
      plus_lo   = RST_PLUS_KEY_LOW;
      plus_hi   = RST_PLUS_KEY_HIGH;
      minus_lo  = RST_MINUS_KEY_LOW;
      minus_hi  = RST_MINUS_KEY_HIGH;
      alarm_len = RST_ALARM_LENGTH;
      min_limit = RST_MINUTE_LIMIT;
      mode_q    = MODE_MIN;
      time_q    = '0;
      colon_q   = 1'b1;
      alarm_q   = RST_ALARM_LENGTH;
      buzz_q    = 1'b0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SET_KEY_LOW:    set_low   = pwdata[9:0];
          REG_PLUS_KEY_LOW:   plus_lo   = pwdata[9:0];
          REG_PLUS_KEY_HIGH:  plus_hi   = pwdata[9:0];
          REG_MINUS_KEY_LOW:  minus_lo  = pwdata[9:0];
          REG_MINUS_KEY_HIGH: minus_hi  = pwdata[9:0];
          REG_ALARM_LENGTH:   alarm_len = pwdata[7:0];
          REG_MINUTE_LIMIT:   min_limit = pwdata[6:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (due_results.size() == 0) flag("result arrived with no poll outstanding");
        else compare_result(result, due_results.pop_front());
      end
      if (poll_valid && poll_ready) begin
        step_timer(poll, predicted);
        due_results.push_back(predicted);
      end
    end
    pending = due_results.size();
  end

endmodule

>>> verif/tb_kitchen_countdown_timer_controller.sv
// Testbench top for the kitchen timer: clock, reset, poll and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_kitchen_countdown_timer_controller;
  import kct_pkg::*;

  // Far above the slowest legal run: ~2200 polls, each with a full sender gap and a
  // full receiver stall, plus register writes and the drain between phases.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Address slot past the last register; writes there must change nothing.
  localparam logic [2:0]  REG_SPARE = 3'd7;
  localparam int unsigned OPENING_LEN = 27;

  // Opening sequence under the reset thresholds, {key_level, second_tick} per poll.
  // Walks window edges, minute and second setting (including the blocked sixth press
  // at fifty seconds), run, pause, resume, cancel, a zero-length run into the alarm,
  // and a key press that silences it.
  localparam logic [OPENING_LEN*11-1:0] OPENING = {
    {10'd0,    1'b0}, {10'd400,  1'b0}, {10'd470,  1'b0}, {10'd530,  1'b1},
    {10'd300,  1'b0}, {10'd949,  1'b0}, {10'd950,  1'b0},
    {10'd500,  1'b0}, {10'd500,  1'b0}, {10'd500,  1'b0}, {10'd500,  1'b0},
    {10'd500,  1'b0}, {10'd500,  1'b0},
    {10'd350,  1'b0}, {10'd1023, 1'b0}, {10'd0,    1'b1}, {10'd500,  1'b1},
    {10'd0,    1'b1}, {10'd500,  1'b0}, {10'd350,  1'b1}, {10'd1023, 1'b0},
    {10'd350,  1'b0}, {10'd1023, 1'b0}, {10'd0,    1'b1}, {10'd0,    1'b1},
    {10'd531,  1'b0}, {10'd1023, 1'b1}
  };

  logic              clk;
  logic              rst;
  logic              poll_valid;
  logic              poll_ready;
  poll_t             poll;
  logic              result_valid;
  logic              result_ready;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  logic [2:0]        mode_now;
  int unsigned       pending;
  int unsigned       mismatches;

  // Stimulus-side copy of the thresholds, used only to aim key levels into windows.
  logic [9:0]        set_low  = RST_SET_KEY_LOW;
  logic [9:0]        plus_lo  = RST_PLUS_KEY_LOW;
  logic [9:0]        plus_hi  = RST_PLUS_KEY_HIGH;
  logic [9:0]        minus_lo = RST_MINUS_KEY_LOW;
  logic [9:0]        minus_hi = RST_MINUS_KEY_HIGH;

  // When set, both sides run back to back with no idle cycles.
  logic              quiet = 1'b0;
  int unsigned       polls_sent = 0;
  int unsigned       cycles = 0;

  kitchen_countdown_timer_controller dut (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_ready   (poll_ready),
    .poll         (poll),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  kct_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_ready   (poll_ready),
    .poll         (poll),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mode_now     (mode_now),
    .pending      (pending),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: draw a stall per transaction, then hold ready until one completes.
  initial begin
    int unsigned stall;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = quiet ? 0 : $urandom_range(15, 0);
      if (stall != 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  function automatic bit in_window(input logic [9:0] v, input logic [9:0] lo,
                                   input logic [9:0] hi);
    return v >= lo && v <= hi;
  endfunction

  // Aim a level at the requested key. An empty window falls back to any level; for no
  // key, retry a few draws to land outside every window.
  function automatic logic [9:0] level_for(input logic [1:0] k);
    logic [9:0] v;
    case (k)
      KEY_SET:   v = 10'($urandom_range(1023, set_low));
      KEY_PLUS:  v = (plus_lo <= plus_hi) ? 10'($urandom_range(plus_hi, plus_lo))
                                          : 10'($urandom_range(1023, 0));
      KEY_MINUS: v = (minus_lo <= minus_hi) ? 10'($urandom_range(minus_hi, minus_lo))
                                            : 10'($urandom_range(1023, 0));
      default: begin
        v = 10'($urandom_range(1023, 0));
        for (int i = 0; i < 16 && (v >= set_low || in_window(v, plus_lo, plus_hi) ||
                                   in_window(v, minus_lo, minus_hi)); i++)
          v = 10'($urandom_range(1023, 0));
      end
    endcase
    return v;
  endfunction

  // Key mix per mode, out of 200: favor paths that carry a session through setting,
  // running and into the alarm; cancels while running stay rare so countdowns finish.
  function automatic logic [1:0] choose_key(input logic [2:0] mode);
    int unsigned p;
    p = $urandom_range(199, 0);
    case (mode)
      MODE_MIN:   return p < 30 ? KEY_PLUS : p < 60 ? KEY_MINUS : p < 140 ? KEY_SET : KEY_NONE;
      MODE_SEC:   return p < 60 ? KEY_PLUS : p < 100 ? KEY_MINUS : p < 140 ? KEY_SET : KEY_NONE;
      MODE_RUN:   return p < 2 ? KEY_PLUS : p < 3 ? KEY_MINUS : p < 4 ? KEY_SET : KEY_NONE;
      MODE_PAUSE: return p < 80 ? KEY_PLUS : p < 94 ? KEY_MINUS : p < 100 ? KEY_SET : KEY_NONE;
      default:    return p < 10 ? KEY_PLUS : p < 17 ? KEY_MINUS : p < 24 ? KEY_SET : KEY_NONE;
    endcase
  endfunction

  function automatic int unsigned tick_odds(input logic [2:0] mode);
    case (mode)
      MODE_RUN:   return 70;
      MODE_ALARM: return 60;
      default:    return 30;
    endcase
  endfunction

  // Call at a falling edge. Idle for a random gap, present the poll, and hold it
  // until the transaction completes; returns just after that rising edge.
  task automatic send_poll(input logic [9:0] lvl, input logic tick);
    int unsigned gap;
    polls_sent++;
    if (polls_sent % 80 == 0) quiet = ($urandom_range(3, 0) == 0);
    gap = quiet ? 0 : $urandom_range(15, 0);
    if (gap != 0) begin
      poll_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll.key_level   = lvl;
    poll.second_tick = tick;
    poll_valid       = 1'b1;
    @(posedge clk);
    while (!poll_ready) @(posedge clk);
  endtask

  // Mostly mode-aware sessions with random content; one poll in twenty is raw noise.
  // mode_now is read at the falling edge, after the checker has taken the last poll.
  task automatic guided_polls(input int unsigned n);
    logic [1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      @(negedge clk);
      if ($urandom_range(19, 0) == 0) begin
        send_poll(10'($urandom_range(1023, 0)), 1'($urandom_range(1, 0)));
      end else begin
        k = choose_key(mode_now);
        send_poll(level_for(k), $urandom_range(99, 0) < tick_odds(mode_now));
      end
    end
  endtask

  // Drive the controller back to setting minutes: set leaves seconds, minus cancels
  // a run or pause, any key ends the alarm.
  task automatic reach_start;
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      if (mode_now != MODE_MIN)
        send_poll(level_for(mode_now == MODE_SEC ? KEY_SET : KEY_MINUS), 1'b0);
    end
  endtask

  // Push minutes past the limit, seconds past fifty, then run briefly and cancel.
  task automatic long_minutes;
    reach_start();
    repeat (101) begin
      @(negedge clk);
      send_poll(level_for(KEY_PLUS), 1'b0);
    end
    @(negedge clk);
    send_poll(level_for(KEY_SET), 1'b0);
    repeat (6) begin
      @(negedge clk);
      send_poll(level_for(KEY_PLUS), 1'b0);
    end
    @(negedge clk);
    send_poll(level_for(KEY_MINUS), 1'b0);
    @(negedge clk);
    send_poll(level_for(KEY_SET), 1'b0);
    repeat (5) begin
      @(negedge clk);
      send_poll(level_for(KEY_NONE), 1'b1);
    end
    @(negedge clk);
    send_poll(level_for(KEY_MINUS), 1'b0);
  endtask

  // Drop valid, drain every outstanding result, then let the two-stage pipeline empty.
  task automatic settle;
    @(negedge clk);
    poll_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Setup phase then access phase; the write lands when pready is seen high.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_SET_KEY_LOW:    set_low  = val[9:0];
      REG_PLUS_KEY_LOW:   plus_lo  = val[9:0];
      REG_PLUS_KEY_HIGH:  plus_hi  = val[9:0];
      REG_MINUS_KEY_LOW:  minus_lo = val[9:0];
      REG_MINUS_KEY_HIGH: minus_hi = val[9:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [9:0] sk, input logic [9:0] pl,
                             input logic [9:0] ph, input logic [9:0] ml,
                             input logic [9:0] mh, input logic [7:0] al,
                             input logic [6:0] lim);
    write_reg(REG_SET_KEY_LOW, {22'd0, sk});
    write_reg(REG_PLUS_KEY_LOW, {22'd0, pl});
    write_reg(REG_PLUS_KEY_HIGH, {22'd0, ph});
    write_reg(REG_MINUS_KEY_LOW, {22'd0, ml});
    write_reg(REG_MINUS_KEY_HIGH, {22'd0, mh});
    write_reg(REG_ALARM_LENGTH, {24'd0, al});
    write_reg(REG_MINUTE_LIMIT, {25'd0, lim});
  endtask

  initial begin
    logic [10:0] item;
    logic [9:0]  pl;
    logic [9:0]  ml;
    rst        = 1'b1;
    poll_valid = 1'b0;
    poll       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk under the reset thresholds.
    for (int i = 0; i < OPENING_LEN; i++) begin
      @(negedge clk);
      item = OPENING[(OPENING_LEN - 1 - i) * 11 +: 11];
      send_poll(item[10:1], item[0]);
    end
    settle();

    // Set key only at full scale, plus window starting at zero, one-second alarm,
    // minute limit of zero so plus never adds minutes.
    program_all(10'd1023, 10'd0, 10'd100, 10'd101, 10'd900, 8'd1, 7'd0);
    guided_polls(300);
    settle();

    // Every level reads as set; empty plus window; longest alarm; one-minute limit.
    program_all(10'd0, 10'd1023, 10'd0, 10'd600, 10'd600, 8'd255, 7'd1);
    guided_polls(60);
    settle();

    // Zero alarm length and a limit above 99, which must clamp to 99.
    program_all(10'd800, 10'd200, 10'd300, 10'd400, 10'd500, 8'd0, 7'd127);
    long_minutes();
    guided_polls(250);
    settle();

    // Random but well-separated windows, short alarms.
    for (int ph = 0; ph < 4; ph++) begin
      pl = 10'($urandom_range(400, 200));
      ml = 10'($urandom_range(150, 0));
      program_all(10'($urandom_range(1023, 700)), pl, 10'(pl + $urandom_range(150, 0)), ml,
                  10'(ml + $urandom_range(40, 0)), 8'($urandom_range(12, 1)),
                  7'($urandom_range(99, 1)));
      if (ph == 0) write_reg(REG_SPARE, $urandom);
      guided_polls(330);
      settle();
    end

    @(negedge clk);
    poll_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/kct_pkg.sv
rtl/kitchen_countdown_timer_controller.sv
rtl/kct_checker.sv
verif/kct_result_checker.sv
verif/tb_kitchen_countdown_timer_controller.sv
